/* src/ntpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpc_pkg
// Shared types and constants for the NTP seconds to calendar converter.
// ----------------------------------------------------------------------------
package ntpc_pkg;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NOT_SERVER   = 2'd1,
      ST_BEFORE_EPOCH = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_ZONE_HOURS   = 1'b0,
      REG_ZONE_MINUTES = 1'b1
   } reg_index_type;

   localparam logic [2:0]  MODE_SERVER  = 3'd4;
   localparam logic [33:0] EPOCH_NTP    = 34'd3565987200;   // 1 Jan 2013, NTP seconds
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN = 6'd60;
   localparam logic [10:0] BASE_YEAR    = 11'd2013;

   localparam logic [11:0] ZONE_HOUR_SECS = 12'd3600;
   localparam logic [5:0]  ZONE_MIN_SECS  = 6'd60;

   // reciprocals: day is floor (corrected afterwards), the others round up
   localparam logic [23:0] DAY_RECIP  = 24'd12725829;       // 2^33 / 675
   localparam logic [15:0] HOUR_RECIP = 16'd37283;          // 2^27 / 3600
   localparam logic [14:0] WEEK_RECIP = 15'd18725;          // 2^17 / 7
   localparam logic [12:0] MIN_RECIP  = 13'd4370;           // 2^18 / 60

   localparam int YEAR_COUNT = 24;                          // 2013 .. 2036

   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // first day of year BASE_YEAR + idx, counted from 1 Jan 2013
   function automatic logic [13:0] year_start(input logic [4:0] idx);
      return 14'(14'(idx) * 14'd365 + 14'(idx >> 2));
   endfunction

endpackage
`default_nettype wire

/* src/ntpc_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpc_csr
// Time zone registers and the zone offset in seconds derived from them.
// ----------------------------------------------------------------------------
module ntpc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data,
   output logic [19:0] zone_offset
);
   import ntpc_pkg::*;

   logic [7:0] zone_hours_ff, zone_hours_in;
   logic [7:0] zone_minutes_ff, zone_minutes_in;

   assign csr_ready = 1'b1;

   always_comb begin
      zone_hours_in   = zone_hours_ff;
      zone_minutes_in = zone_minutes_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_ZONE_HOURS:   zone_hours_in   = csr_data;
            REG_ZONE_MINUTES: zone_minutes_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_hours_ff   <= 8'd10;
         zone_minutes_ff <= 8'd0;
      end else begin
         zone_hours_ff   <= zone_hours_in;
         zone_minutes_ff <= zone_minutes_in;
      end
   end

   assign zone_offset = 20'(20'(zone_hours_ff) * 20'(ZONE_HOUR_SECS))
                      + 20'(20'(zone_minutes_ff) * 20'(ZONE_MIN_SECS));

endmodule
`default_nettype wire

/* src/ntp_seconds_to_calendar.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar
// Converts NTP reply transmit seconds to local Gregorian date and time.
// ----------------------------------------------------------------------------
// Takes one reply word per cycle while not stalled and returns its result
// through an eight-stage register pipeline (offset add, day reciprocal
// multiply, remainder, correction, year and hour split, month and weekday,
// minute, second). Each stage holds its word while the next is full, so a
// stalled result side empties bubbles without losing anything. Time zone
// registers apply to words accepted on the cycle after the write.
module ntp_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // header_byte[7:0], transmit_seconds[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // weekday[2:0], year[13:3], month[17:14],
                                    // day_of_month[22:18], hour[27:23],
                                    // minute[33:28], second[39:34]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import ntpc_pkg::*;

   logic [19:0] zone_offset;

   ntpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .zone_offset (zone_offset)
   );

   // ---------------- pipeline control ----------------
   logic [8:1] valid_ff, valid_in, adv;

   always_comb begin
      adv[8] = !valid_ff[8] || rsp_tready;
      for (int k = 7; k >= 1; k--) adv[k] = !valid_ff[k] || adv[k+1];
      valid_in[1] = adv[1] ? req_tvalid : valid_ff[1];
      for (int k = 2; k <= 8; k++) valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   assign req_tready = adv[1];

   // ---------------- stage 1: mode test, epoch and zone ----------------
   logic [33:0] local1;
   status_type  status1_ff, status1_in;
   logic [29:0] elapsed1_ff, elapsed1_in;

   always_comb begin
      local1 = 34'({2'b00, req_tdata[39:8]}) + 34'(zone_offset) - EPOCH_NTP;
      if (req_tdata[2:0] != MODE_SERVER) status1_in = ST_NOT_SERVER;
      else if (local1[33])               status1_in = ST_BEFORE_EPOCH;
      else                               status1_in = ST_OK;
      elapsed1_in = local1[29:0];
   end

   // ---------------- stage 2: day estimate ----------------
   logic [46:0] day_prod2;
   status_type  status2_ff;
   logic [29:0] elapsed2_ff;
   logic [13:0] quot2_ff, quot2_in;

   always_comb begin
      day_prod2 = 47'(elapsed1_ff[29:7]) * 47'(DAY_RECIP);
      quot2_in  = day_prod2[46:33];
   end

   // ---------------- stage 3: remainder of estimate ----------------
   logic [30:0] day_secs3;
   status_type  status3_ff;
   logic [13:0] quot3_ff;
   logic [17:0] rem3_ff, rem3_in;

   always_comb begin
      day_secs3 = 31'(quot2_ff) * 31'(SECS_PER_DAY);
      rem3_in   = 18'(31'(elapsed2_ff) - day_secs3);
   end

   // ---------------- stage 4: correction ----------------
   status_type  status4_ff;
   logic [13:0] days4_ff, days4_in;
   logic [16:0] rem4_ff, rem4_in;

   always_comb begin
      if (rem3_ff >= 18'(SECS_PER_DAY)) begin
         days4_in = quot3_ff + 14'd1;
         rem4_in  = 17'(rem3_ff - 18'(SECS_PER_DAY));
      end else begin
         days4_in = quot3_ff;
         rem4_in  = rem3_ff[16:0];
      end
   end

   // ---------------- stage 5: year, hour, week quotient ----------------
   logic [32:0] hour_prod5;
   logic [28:0] week_prod5;
   logic [13:0] ystart5;
   status_type  status5_ff;
   logic [4:0]  yidx5_ff, yidx5_in;
   logic [8:0]  doy5_ff, doy5_in;
   logic [4:0]  hour5_ff, hour5_in;
   logic [10:0] wkq5_ff, wkq5_in;
   logic [13:0] days5_ff;
   logic [16:0] rem5_ff;

   always_comb begin
      yidx5_in = '0;
      ystart5  = '0;
      for (int i = 1; i < YEAR_COUNT; i++) begin
         if (days4_ff >= year_start(5'(i))) begin
            yidx5_in = 5'(i);
            ystart5  = year_start(5'(i));
         end
      end
      doy5_in    = 9'(days4_ff - ystart5);
      hour_prod5 = 33'(rem4_ff) * 33'(HOUR_RECIP);
      hour5_in   = hour_prod5[31:27];
      week_prod5 = 29'(days4_ff) * 29'(WEEK_RECIP);
      wkq5_in    = week_prod5[27:17];
   end

   // ---------------- stage 6: month, weekday, seconds in hour ----------------
   logic        leap6;
   logic [8:0]  mstart6;
   logic [3:0]  midx6;
   logic [16:0] hour_secs6;
   logic [13:0] week_days6;
   status_type  status6_ff;
   logic [2:0]  weekday6_ff, weekday6_in;
   logic [10:0] year6_ff, year6_in;
   logic [3:0]  month6_ff, month6_in;
   logic [4:0]  mday6_ff, mday6_in;
   logic [4:0]  hour6_ff;
   logic [11:0] hrem6_ff, hrem6_in;

   always_comb begin
      leap6   = (yidx5_ff[1:0] == 2'b11);   // valid up to 2099
      midx6   = '0;
      mstart6 = '0;
      for (int m = 1; m < 12; m++) begin
         if (doy5_ff >= MONTH_START[m] + 9'((leap6 && m >= 2) ? 1 : 0)) begin
            midx6   = 4'(m);
            mstart6 = MONTH_START[m] + 9'((leap6 && m >= 2) ? 1 : 0);
         end
      end
      month6_in   = midx6 + 4'd1;
      mday6_in    = 5'(doy5_ff - mstart6 + 9'd1);
      year6_in    = BASE_YEAR + 11'(yidx5_ff);
      hour_secs6  = 17'(hour5_ff) * 17'(SECS_PER_HOUR);
      hrem6_in    = 12'(rem5_ff - hour_secs6);
      week_days6  = 14'(wkq5_ff) * 14'd7;
      weekday6_in = 3'(days5_ff - week_days6);
   end

   // ---------------- stage 7: minute ----------------
   logic [24:0] min_prod7;
   status_type  status7_ff;
   logic [2:0]  weekday7_ff;
   logic [10:0] year7_ff;
   logic [3:0]  month7_ff;
   logic [4:0]  mday7_ff;
   logic [4:0]  hour7_ff;
   logic [11:0] hrem7_ff;
   logic [5:0]  minute7_ff, minute7_in;

   always_comb begin
      min_prod7  = 25'(hrem6_ff) * 25'(MIN_RECIP);
      minute7_in = min_prod7[23:18];
   end

   // ---------------- stage 8: second and output word ----------------
   logic [11:0] min_secs8;
   logic [5:0]  second8;
   logic [39:0] rsp_tdata_ff, rsp_tdata_in;
   status_type  rsp_tuser_ff;

   always_comb begin
      min_secs8 = 12'(minute7_ff) * 12'(SECS_PER_MIN);
      second8   = 6'(hrem7_ff - min_secs8);
      if (status7_ff == ST_OK)
         rsp_tdata_in = {second8, minute7_ff, hour7_ff, mday7_ff, month7_ff,
                         year7_ff, weekday7_ff};
      else
         rsp_tdata_in = '0;
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         status1_ff  <= status1_in;
         elapsed1_ff <= elapsed1_in;
      end
      if (adv[2]) begin
         status2_ff  <= status1_ff;
         elapsed2_ff <= elapsed1_ff;
         quot2_ff    <= quot2_in;
      end
      if (adv[3]) begin
         status3_ff <= status2_ff;
         quot3_ff   <= quot2_ff;
         rem3_ff    <= rem3_in;
      end
      if (adv[4]) begin
         status4_ff <= status3_ff;
         days4_ff   <= days4_in;
         rem4_ff    <= rem4_in;
      end
      if (adv[5]) begin
         status5_ff <= status4_ff;
         yidx5_ff   <= yidx5_in;
         doy5_ff    <= doy5_in;
         hour5_ff   <= hour5_in;
         wkq5_ff    <= wkq5_in;
         days5_ff   <= days4_ff;
         rem5_ff    <= rem4_ff;
      end
      if (adv[6]) begin
         status6_ff  <= status5_ff;
         weekday6_ff <= weekday6_in;
         year6_ff    <= year6_in;
         month6_ff   <= month6_in;
         mday6_ff    <= mday6_in;
         hour6_ff    <= hour5_ff;
         hrem6_ff    <= hrem6_in;
      end
      if (adv[7]) begin
         status7_ff  <= status6_ff;
         weekday7_ff <= weekday6_ff;
         year7_ff    <= year6_ff;
         month7_ff   <= month6_ff;
         mday7_ff    <= mday6_ff;
         hour7_ff    <= hour6_ff;
         hrem7_ff    <= hrem6_ff;
         minute7_ff  <= minute7_in;
      end
      if (adv[8]) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= status7_ff;
      end
   end

   assign rsp_tvalid = valid_ff[8];
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
`default_nettype wire

/* src/ntpc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpc_checker
// Port-level checks on the NTP seconds to calendar converter.
// ----------------------------------------------------------------------------
module ntpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import ntpc_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // rejected replies carry no date
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0)
      else $error("error word with non-zero fields");

   // a good word has a sane calendar
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_OK) |->
         rsp_tdata[2:0] < 3'd7 && rsp_tdata[13:3] >= 11'd2013 &&
         rsp_tdata[17:14] >= 4'd1 && rsp_tdata[17:14] <= 4'd12 &&
         rsp_tdata[22:18] >= 5'd1 && rsp_tdata[27:23] < 5'd24 &&
         rsp_tdata[33:28] < 6'd60 && rsp_tdata[39:34] < 6'd60)
      else $error("calendar field out of range");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind ntp_seconds_to_calendar ntpc_checker u_ntpc_checker (.*);
`default_nettype wire
